// ===== hdl/alle_pkg.sv =====
// shared types, codes and microcode program of the array linked list engine
// used by alle_useq and array_linked_list_engine_top; depends on nothing else
package alle_pkg;

	// field widths of the stream words
	localparam int KIND_W   = 2;
	localparam int POS_W    = 11;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 32;

	// operation kinds
	localparam logic [KIND_W-1:0] K_INS_HEAD  = 2'd0;
	localparam logic [KIND_W-1:0] K_INS_AFTER = 2'd1;
	localparam logic [KIND_W-1:0] K_DELETE    = 2'd2;
	localparam logic [KIND_W-1:0] K_READ      = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_END    = 2'd3;

	// microcode step addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] U_INS_HEAD     = 4'd0;
	localparam logic [STEP_W-1:0] U_INS_AFT_CHK  = 4'd1;
	localparam logic [STEP_W-1:0] U_INS_AFT_NEW  = 4'd2;
	localparam logic [STEP_W-1:0] U_INS_AFT_LINK = 4'd3;
	localparam logic [STEP_W-1:0] U_DEL_HEAD_CHK = 4'd4;
	localparam logic [STEP_W-1:0] U_DEL_HEAD_UPD = 4'd5;
	localparam logic [STEP_W-1:0] U_DEL_K_CHK    = 4'd6;
	localparam logic [STEP_W-1:0] U_DEL_K_NEXT   = 4'd7;
	localparam logic [STEP_W-1:0] U_DEL_K_UPD    = 4'd8;
	localparam logic [STEP_W-1:0] U_RD_SEEK      = 4'd9;
	localparam logic [STEP_W-1:0] U_RD_FETCH     = 4'd10;
	localparam logic [STEP_W-1:0] U_RD_OUT       = 4'd11;

	// abort conditions tested by a step
	typedef enum logic [2:0] {
		C_NONE,
		C_FULL,
		C_FULL_KBAD,
		C_KBAD,
		C_HEADBAD,
		C_LINKBAD,
		C_CURBAD
	} cond_t;

	// memory address source
	typedef enum logic [2:0] {
		A_ALLOC,
		A_K,
		A_HEAD,
		A_LINK,
		A_CUR
	} addr_sel_t;

	// link write data source
	typedef enum logic [1:0] {
		LD_HEAD,
		LD_LINK,
		LD_ALLOC
	} ldat_t;

	// head register update
	typedef enum logic [1:0] {
		H_KEEP,
		H_ALLOC,
		H_LINK
	} head_sel_t;

	// cursor register update
	typedef enum logic [1:0] {
		CU_KEEP,
		CU_HEAD_IF_POS0,
		CU_LINK
	} cur_sel_t;

	// one control word
	typedef struct packed {
		cond_t                cond;
		logic [STATUS_W-1:0]  fail_st;
		addr_sel_t            addr;
		logic                 rd;
		logic                 lwr;
		ldat_t                ldat;
		logic                 vwr;
		head_sel_t            head;
		logic                 alloc_inc;
		cur_sel_t             cur;
		logic                 rv_ld;
		logic                 fin;
	} ctrl_t;

	// datapath feedback to the sequencer
	typedef struct packed {
		logic go;
		logic done;
	} seq_fb_t;

	// first step of each operation
	function automatic logic [STEP_W-1:0] entry_of(input logic [KIND_W-1:0] kind,
		input logic pos_zero);
		logic [STEP_W-1:0] e;
		e = U_INS_HEAD;
		unique case (kind)
			K_INS_HEAD:  e = U_INS_HEAD;
			K_INS_AFTER: e = U_INS_AFT_CHK;
			K_DELETE:    e = pos_zero ? U_DEL_HEAD_CHK : U_DEL_K_CHK;
			K_READ:      e = U_RD_SEEK;
		endcase
		return e;
	endfunction

	// microcode program
	function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w.cond      = C_NONE;
		w.fail_st   = ST_OK;
		w.addr      = A_ALLOC;
		w.rd        = 1'b0;
		w.lwr       = 1'b0;
		w.ldat      = LD_HEAD;
		w.vwr       = 1'b0;
		w.head      = H_KEEP;
		w.alloc_inc = 1'b0;
		w.cur       = CU_KEEP;
		w.rv_ld     = 1'b0;
		w.fin       = 1'b0;
		unique case (step)
			U_INS_HEAD: begin
				w.cond = C_FULL; w.fail_st = ST_FULL;
				w.addr = A_ALLOC; w.lwr = 1'b1; w.ldat = LD_HEAD; w.vwr = 1'b1;
				w.head = H_ALLOC; w.alloc_inc = 1'b1; w.fin = 1'b1;
			end
			U_INS_AFT_CHK: begin
				w.cond = C_FULL_KBAD; w.addr = A_K; w.rd = 1'b1;
			end
			U_INS_AFT_NEW: begin
				w.addr = A_ALLOC; w.lwr = 1'b1; w.ldat = LD_LINK; w.vwr = 1'b1;
			end
			U_INS_AFT_LINK: begin
				w.addr = A_K; w.lwr = 1'b1; w.ldat = LD_ALLOC;
				w.alloc_inc = 1'b1; w.fin = 1'b1;
			end
			U_DEL_HEAD_CHK: begin
				w.cond = C_HEADBAD; w.fail_st = ST_BADPOS; w.addr = A_HEAD; w.rd = 1'b1;
			end
			U_DEL_HEAD_UPD: begin
				w.head = H_LINK; w.fin = 1'b1;
			end
			U_DEL_K_CHK: begin
				w.cond = C_KBAD; w.fail_st = ST_BADPOS; w.addr = A_K; w.rd = 1'b1;
			end
			U_DEL_K_NEXT: begin
				w.cond = C_LINKBAD; w.fail_st = ST_BADPOS; w.addr = A_LINK; w.rd = 1'b1;
			end
			U_DEL_K_UPD: begin
				w.addr = A_K; w.lwr = 1'b1; w.ldat = LD_LINK; w.fin = 1'b1;
			end
			U_RD_SEEK: begin
				w.cur = CU_HEAD_IF_POS0;
			end
			U_RD_FETCH: begin
				w.cond = C_CURBAD; w.fail_st = ST_END; w.addr = A_CUR; w.rd = 1'b1;
			end
			U_RD_OUT: begin
				w.rv_ld = 1'b1; w.cur = CU_LINK; w.fin = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/alle_useq.sv =====
// microcode sequencer of the array linked list engine: step counter and program table
// depends on alle_pkg
module alle_useq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [alle_pkg::KIND_W-1:0]   kind,
	input  logic                          pos_zero,
	input  alle_pkg::seq_fb_t             fb,
	output logic                          busy,
	output alle_pkg::ctrl_t               ctrl
);
	import alle_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;

	// step counter with dispatch on kind and early exit on abort
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= U_INS_HEAD;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						step_q  <= entry_of(kind, pos_zero);
					end
				end
				S_RUN: begin
					if (fb.go) begin
						if (fb.done) begin
							state_q <= S_IDLE;
						end else begin
							step_q <= step_q + STEP_W'(1);
						end
					end
				end
			endcase
		end
	end

	// control word of the current step
	assign busy = (state_q == S_RUN);
	assign ctrl = ucode_rom(step_q);

endmodule

// ===== hdl/array_linked_list_engine_top.sv =====
// top level of the array linked list engine: datapath, node memories, result register
// depends on alle_pkg and alle_useq
//
// Usage:
// The slave stream (s_*) takes one command word per operation: tuser holds the
// kind (insert at head, insert after node k, delete, read next), tdata holds the
// 1-based node ordinal and the value to insert. The master stream (m_*) gives
// exactly one result word per command: tdata the value read, tuser the status,
// tlast set when the node read has no successor.
// Each command runs a short microcode program over one synchronous memory port
// shared by the value and link tables. Steps per command: insert at head 1,
// insert after node 3, delete head 2, delete after node 3, read 3; a command
// that fails a check ends at that step. s_tready is high only between commands,
// so a new command is not taken while one runs; the result appears in the
// output register the cycle after the last step.
// The output register decouples the sides: the next command is taken while a
// result still waits. If the receiver stalls and a finished result still sits
// in the register, the last step of the next command holds until it is taken.
// Reset empties the list (head and cursor null, no nodes handed out); the node
// tables are not cleared, since no slot is read before it is written.
module array_linked_list_engine_top #(
	parameter int DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [alle_pkg::S_DATA_W-1:0]   s_tdata,   // position[10:0], value[42:11], zero pad
	input  logic [alle_pkg::KIND_W-1:0]     s_tuser,   // kind[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [alle_pkg::M_DATA_W-1:0]   m_tdata,   // read_value[31:0]
	output logic [alle_pkg::STATUS_W-1:0]   m_tuser,   // status[1:0]
	output logic                            m_tlast
);
	import alle_pkg::*;

	localparam int LW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

	// sequencer interface
	logic       busy;
	ctrl_t      ctrl;
	seq_fb_t    fb;
	logic       accept;

	// command registers
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;

	// list state
	logic [LW-1:0] head_q;
	logic [LW-1:0] alloc_q;
	logic [LW-1:0] cur_q;

	// node memories and their registered read data
	logic signed [VAL_W-1:0] val_mem [DEPTH];
	logic [LW-1:0]           link_mem [DEPTH];
	logic signed [VAL_W-1:0] val_rd_q;
	logic [LW-1:0]           link_rd_q;

	// result register
	logic                    m_tvalid_q;
	logic signed [VAL_W-1:0] rv_q;
	logic [STATUS_W-1:0]     st_q;
	logic                    last_q;

	// datapath signals
	logic [CW-1:0]       k_w;
	logic [LW-1:0]       k_slot;
	logic                k_live;
	logic                full;
	logic                fail;
	logic [STATUS_W-1:0] fail_st;
	logic                ending;
	logic                stall;
	logic                exec;
	logic                act;
	logic [LW-1:0]       slot;
	logic [AW-1:0]       mem_idx;
	logic [LW-1:0]       link_wd;
	logic                val_we;
	logic                link_we;
	logic                rd_en;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !busy;

	alle_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.kind     (s_tuser),
		.pos_zero (s_tdata[POS_W-1:0] == '0),
		.fb       (fb),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	// node ordinal to slot and liveness checks
	assign k_w    = CW'(pos_q) - CW'(1);
	assign k_slot = k_w[LW-1:0];
	assign k_live = (pos_q != '0) && (k_w < CW'(alloc_q));
	assign full   = (alloc_q >= NULL_LINK);

	// abort condition of the current step
	always_comb begin
		fail    = 1'b0;
		fail_st = ctrl.fail_st;
		unique case (ctrl.cond)
			C_NONE:    fail = 1'b0;
			C_FULL:    fail = full;
			C_FULL_KBAD: begin
				fail    = full || !k_live;
				fail_st = full ? ST_FULL : ST_BADPOS;
			end
			C_KBAD:    fail = !k_live;
			C_HEADBAD: fail = !(head_q < alloc_q);
			C_LINKBAD: fail = !(link_rd_q < alloc_q);
			C_CURBAD:  fail = !(cur_q < alloc_q);
			default:   fail = 1'b0;
		endcase
	end

	// step execution, and hold of a command's last step while the result register is occupied and not taken
	assign ending  = ctrl.fin || fail;
	assign stall   = ending && m_tvalid_q && !m_tready;
	assign exec    = busy && !stall;
	assign act     = exec && !fail;
	assign fb.go   = exec;
	assign fb.done = ending;

	// memory address and link write data
	always_comb begin
		unique case (ctrl.addr)
			A_ALLOC: slot = alloc_q;
			A_K:     slot = k_slot;
			A_HEAD:  slot = head_q;
			A_LINK:  slot = link_rd_q;
			A_CUR:   slot = cur_q;
			default: slot = alloc_q;
		endcase
		unique case (ctrl.ldat)
			LD_HEAD:  link_wd = head_q;
			LD_LINK:  link_wd = link_rd_q;
			LD_ALLOC: link_wd = alloc_q;
			default:  link_wd = head_q;
		endcase
	end

	assign mem_idx = slot[AW-1:0];
	assign val_we  = act && ctrl.vwr;
	assign link_we = act && ctrl.lwr;
	assign rd_en   = act && ctrl.rd;

	// value table
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[mem_idx] <= val_q;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[mem_idx];
		end
	end

	// link table
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[mem_idx] <= link_wd;
		end
		if (rd_en) begin
			link_rd_q <= link_mem[mem_idx];
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= s_tdata[POS_W-1:0];
			val_q <= s_tdata[POS_W +: VAL_W];
		end
	end

	// list state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NULL_LINK;
			alloc_q <= '0;
			cur_q   <= NULL_LINK;
		end else if (act) begin
			unique case (ctrl.head)
				H_KEEP:  head_q <= head_q;
				H_ALLOC: head_q <= alloc_q;
				H_LINK:  head_q <= link_rd_q;
				default: head_q <= head_q;
			endcase
			if (ctrl.alloc_inc) begin
				alloc_q <= alloc_q + LW'(1);
			end
			unique case (ctrl.cur)
				CU_KEEP:         cur_q <= cur_q;
				CU_HEAD_IF_POS0: cur_q <= (pos_q == '0) ? head_q : cur_q;
				CU_LINK:         cur_q <= link_rd_q;
				default:         cur_q <= cur_q;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec && ending) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exec && ending) begin
			st_q   <= fail ? fail_st : ST_OK;
			rv_q   <= (act && ctrl.rv_ld) ? val_rd_q : '0;
			last_q <= act && ctrl.rv_ld && !(link_rd_q < alloc_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = rv_q;
	assign m_tuser  = st_q;
	assign m_tlast  = last_q;

	// checks
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= NULL_LINK)
		else $error("node count beyond table depth");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (alloc_q == $past(alloc_q)) || (alloc_q == $past(alloc_q) + LW'(1)))
		else $error("node count moved by more than one");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(val_we || link_we) |-> busy)
		else $error("table write outside a command");

	a_head_cur_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((head_q == NULL_LINK) || (head_q < alloc_q))
		&& ((cur_q == NULL_LINK) || (cur_q < alloc_q)))
		else $error("head or cursor names an unallocated slot");

endmodule
